>>> rtl/lbph_pkg.sv
// lbph_pkg: shared widths, codes, handshake structs and the pattern-to-bin table
// for the uniform lbp histogram block
// no dependencies
package lbph_pkg;

    localparam int PIX_W            = 8;
    localparam int CFG_W            = 11;
    localparam int CFG_IDX_W        = 2;
    localparam int BIN_W            = 6;
    localparam int COUNT_W          = 21;
    localparam int NUM_BINS         = 59;
    localparam int NONUNIFORM_BIN   = 58;
    localparam int MAX_HEIGHT       = 1024;
    localparam int ROW_W            = $clog2(MAX_HEIGHT);
    localparam int MIN_DIM          = 3;
    localparam int WIN_MARGIN       = 2;
    localparam int CODE_W           = 8;
    localparam int NUM_CODES        = 256;
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [BIN_W-1:0]   t_bin;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [CODE_W-1:0]  t_code;

    // pixel tag travelling with the word through the window stage
    typedef struct packed {
        logic vld;
        logic cnt;
        logic last;
    } t_tag;

    // histogram update request from the window stage
    typedef struct packed {
        logic  vld;
        logic  cnt;
        logic  last;
        t_code code;
    } t_upd;

    // dump control from the sequencer
    typedef struct packed {
        logic rd_en;
        t_bin addr;
        logic clear;
    } t_dump_ctl;

    // histogram status back to the sequencer
    typedef struct packed {
        logic   done_last;
        t_count rd_count;
    } t_hist_stat;

    typedef logic [NUM_CODES-1:0][BIN_W-1:0] t_lut;

    function automatic logic [2:0] edge_count(input t_code code);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < CODE_W - 1; i++) begin
            n = n + {2'b00, code[i] ^ code[i+1]};
        end
        return n;
    endfunction

    function automatic t_lut build_lut();
        t_lut lut;
        int   rank;
        int   c;
        rank = 0;
        for (c = 0; c < NUM_CODES; c++) begin
            if (edge_count(CODE_W'(c)) <= 3'd2) begin
                lut[c] = BIN_W'(rank);
                rank   = rank + 1;
            end else begin
                lut[c] = BIN_W'(NONUNIFORM_BIN);
            end
        end
        return lut;
    endfunction

    localparam t_lut BIN_LUT = build_lut();

endpackage

>>> rtl/lbph_window.sv
// lbph_window: two line store memories, the 3x3 window registers and the
// neighbour compare that forms the 8-bit pattern
// depends on lbph_pkg
module lbph_window
    import lbph_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  t_pix                         i_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  t_tag                         i_tag,
    output t_upd                         o_upd
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    t_pix mem_upper  [MAX_WIDTH];
    t_pix mem_middle [MAX_WIDTH];

    t_pix             r_top;
    t_pix             r_mid;
    t_pix             r_px1;
    logic [COL_W-1:0] r_col1;
    t_tag             r_tag1;
    t_pix             r_win [6];
    t_upd             r_upd;
    t_code            n_code;
    t_pix             nb [8];

    // read at the accepted column, write back in the cycle after
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_top <= mem_upper[i_col];
            r_mid <= mem_middle[i_col];
        end
        if (r_tag1.vld) begin
            mem_upper[r_col1]  <= r_mid;
            mem_middle[r_col1] <= r_px1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
        end else begin
            r_tag1 <= i_acc ? i_tag : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_px1  <= i_pixel;
            r_col1 <= i_col;
        end
    end

    always_comb begin
        nb[0] = r_win[0];
        nb[1] = r_win[3];
        nb[2] = r_top;
        nb[3] = r_win[1];
        nb[4] = r_mid;
        nb[5] = r_win[2];
        nb[6] = r_win[5];
        nb[7] = r_px1;
        for (int i = 0; i < CODE_W; i++) begin
            n_code[i] = nb[i] > r_win[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tag1.vld) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_top;
            r_win[4] <= r_mid;
            r_win[5] <= r_px1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd <= '0;
        end else begin
            r_upd.vld  <= r_tag1.vld;
            r_upd.cnt  <= r_tag1.vld & r_tag1.cnt;
            r_upd.last <= r_tag1.vld & r_tag1.last;
            r_upd.code <= n_code;
        end
    end

    assign o_upd = r_upd;

endmodule

>>> rtl/lbph_hist.sv
// lbph_hist: bin count memory with read-modify-write, forwarding between
// back-to-back updates of one bin, valid bits and the dump read port
// depends on lbph_pkg
module lbph_hist
    import lbph_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_upd       i_upd,
    input  t_dump_ctl  i_dump,
    output t_hist_stat o_stat
);

    t_count mem [NUM_BINS];

    logic [NUM_BINS-1:0] r_valid;
    t_count              r_rdata;
    logic                r_rd_vld;
    logic                r_s3_vld;
    logic                r_s3_cnt;
    logic                r_s3_last;
    t_bin                r_s3_bin;
    logic                r_fwd;
    t_count              r_fwd_data;

    t_bin   bin;
    logic   s2_cnt;
    logic   rd_en;
    t_bin   rd_addr;
    t_count old_cnt;
    t_count n_cnt;

    assign bin     = BIN_LUT[i_upd.code];
    assign s2_cnt  = i_upd.vld & i_upd.cnt;
    assign rd_en   = i_dump.rd_en | s2_cnt;
    assign rd_addr = i_dump.rd_en ? i_dump.addr : bin;

    assign old_cnt = r_fwd ? r_fwd_data : (r_rd_vld ? r_rdata : '0);
    assign n_cnt   = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata  <= mem[rd_addr];
            r_rd_vld <= r_valid[rd_addr];
        end
        if (r_s3_cnt) begin
            mem[r_s3_bin] <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_s3_vld  <= 1'b0;
            r_s3_cnt  <= 1'b0;
            r_s3_last <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (i_dump.clear) begin
                r_valid <= '0;
            end else if (r_s3_cnt) begin
                r_valid[r_s3_bin] <= 1'b1;
            end
            r_s3_vld  <= i_upd.vld;
            r_s3_cnt  <= s2_cnt;
            r_s3_last <= i_upd.vld & i_upd.last;
            r_fwd     <= s2_cnt & r_s3_cnt & (bin == r_s3_bin);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_bin   <= bin;
        r_fwd_data <= n_cnt;
    end

    assign o_stat.done_last = r_s3_vld & r_s3_last;
    assign o_stat.rd_count  = r_rd_vld ? r_rdata : '0;

endmodule

>>> rtl/uniform_lbp_histogram_top.sv
// uniform_lbp_histogram_top: position counters, frame-end sequencer, bin dump
// and output register; instantiates lbph_window and lbph_hist, uses lbph_pkg
//
// Pixels are taken one per clock in raster order while no frame-end dump is in
// progress. Each word passes a line store read, a window and compare stage, and
// a bin count read-modify-write, with forwarding so that consecutive pixels may
// hit one bin. On the last pixel of a frame the input is held while the
// pipeline drains, then the 59 bins are read out of the count memory at one
// word per cycle while the output side keeps up. Bin counts clear at once
// through valid bits, with no clearing pass. Width and height are clamped to
// 3..MAX_WIDTH and 3..1024.
module uniform_lbp_histogram_top
    import lbph_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [BIN_W-1:0]     o_bin_index,
    output logic [COUNT_W-1:0]   o_bin_count,
    output logic                 o_last_bin,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WREQ_W  = $clog2(MAX_WIDTH + 1);
    localparam int DIM_W   = (CFG_W > WREQ_W) ? CFG_W : WREQ_W;

    localparam logic [1:0] ST_RUN      = 2'd0;
    localparam logic [1:0] ST_DRAIN    = 2'd1;
    localparam logic [1:0] ST_DUMP_RD  = 2'd2;
    localparam logic [1:0] ST_DUMP_OUT = 2'd3;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    t_bin             r_k;
    logic             r_o_valid;
    t_bin             r_o_index;
    t_count           r_o_count;
    logic             r_o_last;

    logic [DIM_W-1:0] w_cfg;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] col_inc;
    logic [CFG_W-1:0] h_eff;
    logic [CFG_W-1:0] row_inc;
    logic             acc;
    logic             end_row;
    logic             end_frame;
    logic             out_free;
    logic             load;
    logic             k_last;
    t_tag             tag;
    t_dump_ctl        dump;
    t_upd             upd;
    t_hist_stat       stat;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(DEF_FRAME_WIDTH);
            r_frame_height <= CFG_W'(DEF_FRAME_HEIGHT);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg   = DIM_W'(r_frame_width);
    assign w_eff   = (w_cfg < DIM_W'(MIN_DIM))   ? DIM_W'(MIN_DIM) :
                     (w_cfg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_cfg;
    assign h_eff   = (r_frame_height < CFG_W'(MIN_DIM))    ? CFG_W'(MIN_DIM) :
                     (r_frame_height > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) :
                     r_frame_height;
    assign col_inc   = DIM_W'(r_col) + DIM_W'(1);
    assign row_inc   = CFG_W'(r_row) + CFG_W'(1);
    assign end_row   = col_inc >= w_eff;
    assign end_frame = end_row & (row_inc >= h_eff);

    assign o_ready = i_rst_n & (r_state == ST_RUN);
    assign acc     = i_valid & o_ready;

    assign tag.vld  = 1'b1;
    assign tag.cnt  = (r_row >= ROW_W'(WIN_MARGIN)) & (r_col >= COL_W'(WIN_MARGIN));
    assign tag.last = end_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (end_row) begin
                r_col <= '0;
                r_row <= end_frame ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    assign out_free = ~r_o_valid | i_ready;
    assign k_last   = (r_k == BIN_W'(NUM_BINS - 1));
    assign load     = (r_state == ST_DUMP_OUT) & out_free;

    always_comb begin
        n_state    = r_state;
        dump.rd_en = 1'b0;
        dump.addr  = r_k;
        dump.clear = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (acc && end_frame) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (stat.done_last) n_state = ST_DUMP_RD;
            end
            ST_DUMP_RD: begin
                dump.rd_en = 1'b1;
                n_state    = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                if (out_free) begin
                    if (k_last) begin
                        dump.clear = 1'b1;
                        n_state    = ST_RUN;
                    end else begin
                        dump.rd_en = 1'b1;
                        dump.addr  = r_k + BIN_W'(1);
                    end
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_k <= k_last ? '0 : r_k + BIN_W'(1);
            end
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_index <= r_k;
            r_o_count <= stat.rd_count;
            r_o_last  <= k_last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_bin_index = r_o_index;
    assign o_bin_count = r_o_count;
    assign o_last_bin  = r_o_last;

    lbph_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_pixel (i_pixel),
        .i_col   (r_col),
        .i_tag   (tag),
        .o_upd   (upd)
    );

    lbph_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .i_dump  (dump),
        .o_stat  (stat)
    );

endmodule

>>> rtl/lbph_checker.sv
// lbph_checker: port-level assertions on the uniform lbp histogram top level,
// attached by the bind at the end of this file; depends on lbph_pkg
module lbph_checker
    import lbph_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [BIN_W-1:0]     o_bin_index,
    input logic [COUNT_W-1:0]   o_bin_count,
    input logic                 o_last_bin
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bin_index) && $stable(o_bin_count)
            && $stable(o_last_bin))
        else $error("output word changed while stalled");

    a_last_is_nonuniform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_bin |-> o_bin_index == BIN_W'(NONUNIFORM_BIN))
        else $error("final word of burst is not the non-uniform bin");

    a_mid_burst_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_bin |-> o_bin_index < BIN_W'(NONUNIFORM_BIN))
        else $error("bin index out of range mid burst");

    a_input_held_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_bin |-> !o_ready)
        else $error("pixel input open during bin burst");

    a_burst_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_bin ##1 o_valid |->
            o_bin_index == $past(o_bin_index) + BIN_W'(1))
        else $error("bins out of order");

endmodule

bind uniform_lbp_histogram_top lbph_checker u_lbph_checker (.*);
